[rtl/midpoint_circle_raster_unit_assert.svh]
// assertion macros shared by the circle raster files
`ifndef MIDPOINT_CIRCLE_RASTER_UNIT_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MCR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mcr assertion failed");

// next-cycle implication, checked outside reset
`define MCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mcr assertion failed");

`endif

[rtl/mcr_pkg.sv]
package mcr_pkg;

    // width of every output coordinate
    localparam int OUT_BITS = 14;

    // operation codes carried in tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // index of the final result of one iteration
    localparam logic [2:0] IDX_LAST_FILL    = 3'd3;
    localparam logic [2:0] IDX_LAST_OUTLINE = 3'd7;

    // status of the square root unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

endpackage

[rtl/mcr_isqrt.sv]
`include "midpoint_circle_raster_unit_assert.svh"

module mcr_isqrt #(
    parameter int ROOT_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [2*ROOT_BITS-1:0]   i_radicand,
    output mcr_pkg::t_sqrt_stat      o_stat,
    output logic [ROOT_BITS-1:0]     o_root
);

    localparam int SQ_W  = 2 * ROOT_BITS;
    localparam int REM_W = ROOT_BITS + 1;
    localparam int SH_W  = ROOT_BITS + 3;
    localparam int CNT_W = $clog2(ROOT_BITS);

    logic [SQ_W-1:0]      r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [SH_W-1:0] w_sh;
    logic [SH_W-1:0] w_trial;
    logic [SH_W-1:0] w_diff;
    logic            w_take;

    // one root bit per cycle: bring down two radicand bits, try subtract
    assign w_sh    = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_diff  = w_sh - w_trial;
    assign w_take  = (w_sh >= w_trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_BITS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[SQ_W-3:0], 2'b00};
            if (w_take) begin
                r_rem  <= w_diff[REM_W-1:0];
                r_root <= {r_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_sh[REM_W-1:0];
                r_root <= {r_root[ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

    `MCR_ASSERT_NEXT(a_start_busy, i_start, r_busy && (r_cnt == CNT_W'(ROOT_BITS - 1)))
    `MCR_ASSERT_NOW(a_done_idle, r_done, !r_busy)
    `MCR_ASSERT_NEXT(a_last_done, r_busy && (r_cnt == '0) && !i_start, r_done && !r_busy)

endmodule

[rtl/midpoint_circle_raster_unit.sv]
// midpoint circle rasterizer
// input stream: tuser[0] is the operation (0 start, 1 step); tdata holds
//   center x, center y, rim x, rim y from the lowest bit up. a start takes the
//   floor square root of the squared rim distance as radius; a step does one
//   midpoint iteration of the current circle (ignored when none is active).
// output stream: one transaction per point or span, tlast on the final result
//   of the final iteration. outline mode gives 8 results, fill mode 4 spans.
// config: i_cfg_we writes fill_mode (i_cfg_wdata).
// sequence: a start squares both offsets on the shared squarer, launches the
//   square root, runs COORD_BITS+1 bit-serial root steps, seeds the iteration
//   and loads the output register with its first result; a step updates the
//   iteration, enters the emit state and loads its first result.
// flow: results leave one per cycle from the output register while
//   m_axis_tready stays high. tready is high only while the sequencer is idle,
//   and returns as soon as the last result is loaded, even if it still waits.
// stall: a low m_axis_tready holds the output register and pauses the
//   sequencer in its emit state; nothing is dropped.
// reset: synchronous active low; no circle active, fill_mode 0, output empty.
`include "midpoint_circle_raster_unit_assert.svh"

module midpoint_circle_raster_unit #(
    parameter int COORD_BITS = 11
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_wdata,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: center_x_in, center_y_in, rim_x_in, rim_y_in, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // tuser: operation
    input  logic [0:0]                            s_axis_tuser,
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: first_x, first_y, second_x, second_y
    output logic [4*mcr_pkg::OUT_BITS-1:0]        m_axis_tdata,
    // tlast: circle_done
    output logic                                  m_axis_tlast
);

    localparam int ROOT_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int DEC_W  = COORD_BITS + 3;
    localparam int CALC_W = (DEC_W > mcr_pkg::OUT_BITS) ? DEC_W : mcr_pkg::OUT_BITS;
    localparam int OB     = mcr_pkg::OUT_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SQX  = 5'b00010,
        S_SQY  = 5'b00100,
        S_ROOT = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic                          r_fill;
    logic [COORD_BITS-1:0]         r_cx, r_cy;
    logic [COORD_BITS-1:0]         r_dx, r_dy;
    logic [SQ_W-1:0]               r_sq;
    logic                          r_root_go;
    logic [ROOT_W-1:0]             r_ox, r_oy;
    logic signed [DEC_W-1:0]       r_p;
    logic                          r_active;
    logic [2:0]                    r_idx;
    logic                          r_out_valid;
    logic [4*OB-1:0]               r_out_data;
    logic                          r_out_last;

    mcr_pkg::t_sqrt_stat           w_sqrt_stat;
    logic [ROOT_W-1:0]             w_root;

    // input unpack
    logic                          w_in_acc;
    logic                          w_op;
    logic [COORD_BITS-1:0]         w_cx_in, w_cy_in, w_rx_in, w_ry_in;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_op     = s_axis_tuser[0];
    assign w_cx_in  = s_axis_tdata[COORD_BITS-1:0];
    assign w_cy_in  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_rx_in  = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_ry_in  = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    // shared squarer, one operand per cycle
    logic [COORD_BITS-1:0] w_mul_op;
    logic [PROD_W-1:0]     w_prod;

    assign w_mul_op = (r_state == S_SQX) ? r_dx : r_dy;
    assign w_prod   = PROD_W'(w_mul_op) * PROD_W'(w_mul_op);

    // square root unit
    mcr_isqrt #(
        .ROOT_BITS (ROOT_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_root_go),
        .i_radicand (r_sq),
        .o_stat     (w_sqrt_stat),
        .o_root     (w_root)
    );

    // midpoint iteration
    logic [ROOT_W-1:0]       w_x1, w_y1;
    logic                    w_p_neg;
    logic signed [DEC_W-1:0] w_sx1, w_sy1, w_diff, w_p_next;

    assign w_p_neg  = r_p[DEC_W-1];
    assign w_x1     = r_ox + 1'b1;
    assign w_y1     = w_p_neg ? r_oy : r_oy - 1'b1;
    assign w_sx1    = signed'({2'b00, w_x1});
    assign w_sy1    = signed'({2'b00, w_y1});
    assign w_diff   = w_p_neg ? w_sx1 : w_sx1 - w_sy1;
    assign w_p_next = r_p + {w_diff[DEC_W-2:0], 1'b0} + DEC_W'(1);

    // result generation: pick octant offsets by index and mode
    logic                     w_swap, w_negx, w_negy;
    logic [ROOT_W-1:0]        w_u, w_v;
    logic signed [CALC_W-1:0] w_cxe, w_cye, w_ue, w_ve;
    logic signed [CALC_W-1:0] w_ax, w_ayp, w_aym;
    logic [4*OB-1:0]          w_res;
    logic                     w_last_idx;

    always_comb begin
        if (r_fill) begin
            w_swap = r_idx[0];
            w_negx = !r_idx[1];
            w_negy = 1'b0;
        end else begin
            w_swap = r_idx[1];
            w_negx = r_idx[2];
            w_negy = r_idx[0];
        end
    end

    assign w_u   = w_swap ? r_oy : r_ox;
    assign w_v   = w_swap ? r_ox : r_oy;
    assign w_cxe = signed'({{(CALC_W-COORD_BITS){1'b0}}, r_cx});
    assign w_cye = signed'({{(CALC_W-COORD_BITS){1'b0}}, r_cy});
    assign w_ue  = signed'({{(CALC_W-ROOT_W){1'b0}}, w_u});
    assign w_ve  = signed'({{(CALC_W-ROOT_W){1'b0}}, w_v});
    assign w_ax  = w_negx ? w_cxe - w_ue : w_cxe + w_ue;
    assign w_ayp = w_cye + w_ve;
    assign w_aym = w_cye - w_ve;

    always_comb begin
        if (r_fill) begin
            w_res = {w_aym[OB-1:0], w_ax[OB-1:0], w_ayp[OB-1:0], w_ax[OB-1:0]};
        end else if (w_negy) begin
            w_res = {w_aym[OB-1:0], w_ax[OB-1:0], w_aym[OB-1:0], w_ax[OB-1:0]};
        end else begin
            w_res = {w_ayp[OB-1:0], w_ax[OB-1:0], w_ayp[OB-1:0], w_ax[OB-1:0]};
        end
    end

    assign w_last_idx = r_fill ? (r_idx == mcr_pkg::IDX_LAST_FILL)
                               : (r_idx == mcr_pkg::IDX_LAST_OUTLINE);

    // output register may load when empty or being drained
    logic w_load;
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_op == mcr_pkg::OP_START) begin
                        n_state = S_SQX;
                    end else if (r_active) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SQX: begin
                n_state = S_SQY;
            end
            S_SQY: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_sqrt_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load && w_last_idx) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 1'b0;
            r_active    <= 1'b0;
            r_root_go   <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_p         <= '0;
        end else begin
            r_state   <= n_state;
            r_root_go <= (r_state == S_SQY);
            if (i_cfg_we) begin
                r_fill <= i_cfg_wdata;
            end
            // capture a new circle
            if (w_in_acc && (w_op == mcr_pkg::OP_START)) begin
                r_cx <= w_cx_in;
                r_cy <= w_cy_in;
            end
            // one midpoint iteration
            if (w_in_acc && (w_op == mcr_pkg::OP_STEP) && r_active) begin
                r_ox     <= w_x1;
                r_oy     <= w_y1;
                r_p      <= w_p_next;
                r_active <= (w_x1 < w_y1);
                r_idx    <= '0;
            end
            // radius ready: seed the iteration
            if ((r_state == S_ROOT) && w_sqrt_stat.done) begin
                r_ox     <= '0;
                r_oy     <= w_root;
                r_p      <= DEC_W'(1) - signed'({2'b00, w_root});
                r_active <= (w_root != '0);
                r_idx    <= '0;
            end
            // output register
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_op == mcr_pkg::OP_START)) begin
            r_dx <= (w_rx_in >= w_cx_in) ? w_rx_in - w_cx_in : w_cx_in - w_rx_in;
            r_dy <= (w_ry_in >= w_cy_in) ? w_ry_in - w_cy_in : w_cy_in - w_ry_in;
        end
        if (r_state == S_SQX) begin
            r_sq <= SQ_W'(w_prod);
        end else if (r_state == S_SQY) begin
            r_sq <= r_sq + SQ_W'(w_prod);
        end
        if (w_load) begin
            r_out_data <= w_res;
            r_out_last <= w_last_idx && !r_active;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `MCR_ASSERT_NOW(a_active_order, r_active, r_ox < r_oy)
    `MCR_ASSERT_NEXT(a_last_to_idle, w_load && w_last_idx, r_state == S_IDLE)
    `MCR_ASSERT_NEXT(a_emit_holds, (r_state == S_EMIT) && r_out_valid && !m_axis_tready,
                     $stable(r_idx) && (r_state == S_EMIT))

endmodule
